// ===== hw/rtl/scfc_pkg.sv =====
// Package for the sensor frame CRC check and conversion block.
// Holds the frame record type, the conversion constants and the CRC-8 step.
// No dependencies.
package scfc_pkg;

    localparam logic [7:0]  SCFC_POLY_RESET   = 8'h31;
    localparam int          SCFC_QUEUE_DEPTH  = 2;

    localparam logic        KIND_TEMP         = 1'b0;
    localparam logic        KIND_HUMID        = 1'b1;

    localparam logic [15:0] STATUS_MASK       = 16'hFFFC;
    localparam logic [14:0] TEMP_COEF         = 15'd17572;
    localparam logic [14:0] HUMID_COEF        = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET       = 16'd4685;
    localparam logic [15:0] HUMID_OFFSET      = 16'd600;
    localparam logic [15:0] HUMID_MAX         = 16'd10000;

    typedef struct packed {
        logic        crc_ok;
        logic        kind;
        logic [15:0] raw;
    } frame_t;

    function automatic logic [7:0] scfc_crc8(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/scfc_front.sv =====
// Front end: takes frame bytes, keeps the byte slot, data bytes and CRC-8.
// Pushes one checked frame record per CRC byte. Depends on scfc_pkg.
module scfc_front
    import scfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] crc_poly,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // frame_byte
    input  logic [0:0] s_tuser,   // measure_kind
    output logic       push_valid,
    input  logic       push_ready,
    output frame_t     push_data
);

    localparam logic [1:0] POS_HIGH = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_CRC  = 2'd2;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic       accept;

    assign s_tready   = (pos_reg != POS_CRC) || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = s_tvalid && (pos_reg == POS_CRC);

    assign push_data.crc_ok = (crc_reg == s_tdata);
    assign push_data.kind   = s_tuser[0];
    assign push_data.raw    = {high_reg, low_reg};

    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        high_next = high_reg;
        low_next  = low_reg;
        if (accept) begin
            case (pos_reg)
                POS_LOW: begin
                    low_next = s_tdata;
                    crc_next = scfc_crc8(crc_reg, s_tdata, crc_poly);
                    pos_next = POS_CRC;
                end
                POS_CRC: begin
                    crc_next = 8'd0;
                    pos_next = POS_HIGH;
                end
                default: begin
                    high_next = s_tdata;
                    crc_next  = scfc_crc8(8'd0, s_tdata, crc_poly);
                    pos_next  = POS_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HIGH;
            crc_reg <= 8'd0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
        high_reg <= high_next;
        low_reg  <= low_next;
    end

endmodule

// ===== hw/rtl/scfc_queue.sv =====
// Small register queue of frame records between the front and back ends.
// Depends on scfc_pkg for the record type.
module scfc_queue
    import scfc_pkg::*;
#(
    parameter int DEPTH = SCFC_QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  frame_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output frame_t pop_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_t        store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          wr, rd;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign wr         = push_valid && push_ready;
    assign rd         = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (wr) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd && !wr) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

// ===== hw/rtl/scfc_back.sv =====
// Back end: scales the masked raw word by the kind's coefficient, then
// applies the offset and humidity clamp into the output register. Uses scfc_pkg.
module scfc_back
    import scfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  frame_t      pop_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // reading_value[14:0], raw_reading[30:15], zero
    output logic [1:0]  m_tuser    // crc_ok, result_kind
);

    typedef struct packed {
        frame_t      frame;
        logic [14:0] scaled;
    } scaled_t;

    logic          mul_valid_reg, mul_valid_next;
    scaled_t       mul_reg, mul_next;
    logic          out_valid_reg, out_valid_next;
    frame_t        out_frame_reg, out_frame_next;
    logic [14:0]   out_value_reg, out_value_next;

    logic          out_free, mul_free;
    logic [14:0]   coef;
    logic [30:0]   product;
    logic [15:0]   offset, diff;

    assign out_free  = !out_valid_reg || m_tready;
    assign mul_free  = !mul_valid_reg || out_free;
    assign pop_ready = mul_free;

    assign coef    = (pop_data.kind == KIND_HUMID) ? HUMID_COEF : TEMP_COEF;
    assign product = 31'(pop_data.raw & STATUS_MASK) * 31'(coef);

    assign offset = (mul_reg.frame.kind == KIND_HUMID) ? HUMID_OFFSET : TEMP_OFFSET;
    assign diff   = {1'b0, mul_reg.scaled} - offset;

    always_comb begin
        mul_valid_next = mul_valid_reg;
        mul_next       = mul_reg;
        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        out_value_next = out_value_reg;
        if (mul_free) begin
            mul_valid_next = pop_valid;
            mul_next.frame = pop_data;
            mul_next.scaled = product[30:16];
        end
        if (out_free) begin
            out_valid_next = mul_valid_reg;
            out_frame_next = mul_reg.frame;
            if (mul_reg.frame.kind == KIND_HUMID && $signed(diff) > $signed(HUMID_MAX)) begin
                out_value_next = HUMID_MAX[14:0];
            end else begin
                out_value_next = diff[14:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
        mul_reg       <= mul_next;
        out_frame_reg <= out_frame_next;
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_frame_reg.raw, out_value_reg};
    assign m_tuser  = {out_frame_reg.kind, out_frame_reg.crc_ok};

    a_mul_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_valid_reg && !out_free) |=> mul_valid_reg && $stable(mul_reg))
        else $error("scaled stage changed while blocked");

    a_humid_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_frame_reg.kind == KIND_HUMID)
            |-> $signed(out_value_reg) <= $signed(HUMID_MAX[14:0]))
        else $error("humidity above clamp");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while waiting");

endmodule

// ===== hw/rtl/sensor_frame_crc_convert_core.sv =====
// Sensor frame CRC check and conversion, top level.
// Instantiates scfc_front, scfc_queue and scfc_back; uses scfc_pkg.
//
// The block takes one frame byte per cycle (high byte, low byte, CRC byte)
// and never stalls a data byte; a CRC byte waits only while the frame queue
// is full. Each CRC byte yields one result, which passes through the frame
// queue, the 16x15 constant multiplier stage and the offset, clamp and
// output register stage. Results can leave at one per cycle while m_tready
// is high, so sustained input rate is one byte per cycle.
module sensor_frame_crc_convert_core
    import scfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = SCFC_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // crc_polynomial
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // frame_byte
    input  logic [0:0]  s_tuser,      // measure_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // reading_value[14:0], raw_reading[30:15], zero
    output logic [1:0]  m_tuser       // crc_ok, result_kind
);

    logic [7:0] poly_reg;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    frame_t     push_data, pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= SCFC_POLY_RESET;
        end else if (cfg_wr_en) begin
            poly_reg <= cfg_wr_data;
        end
    end

    scfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .crc_poly   (poly_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    scfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== sim/tb_sensor_frame_crc_convert_core.sv =====
// Testbench for sensor_frame_crc_convert_core: byte frames in, checked readings out.
// A clocked driver and monitor compare each result against a local frame predictor.
// Depends on scfc_pkg and the core RTL only.
module tb_sensor_frame_crc_convert_core
    import scfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 190;

    typedef struct {
        logic [7:0] frame_byte;
        logic       measure_kind;
    } frame_item_t;

    typedef struct {
        logic        crc_ok;
        logic        kind;
        logic [14:0] value;
        logic [15:0] raw;
    } reading_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic [0:0]  s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    frame_item_t byte_queue[$];
    reading_t    expected_readings[$];
    int          error_count = 0;
    int          cycle_count = 0;

    logic [7:0]  model_poly = SCFC_POLY_RESET;
    logic [1:0]  model_position = 2'd0;
    logic [7:0]  model_crc = 8'h00;
    logic [7:0]  model_high = 8'h00;
    logic [7:0]  model_low = 8'h00;

    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_phase = 0;
    int          stall_round = 0;

    sensor_frame_crc_convert_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] acc;
        acc = crc ^ data;
        repeat (8) begin
            if (acc[7]) begin
                acc = {acc[6:0], 1'b0} ^ poly;
            end else begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    function automatic logic [14:0] convert_raw(input logic [15:0] raw, input logic kind);
        int unsigned masked;
        int          value;
        masked = 32'(raw & STATUS_MASK);
        if (kind == KIND_HUMID) begin
            value = -600 + int'((12500 * masked) >> 16);
            if (value > 10000) begin
                value = 10000;
            end
        end else begin
            value = -4685 + int'((17572 * masked) >> 16);
        end
        return value[14:0];
    endfunction

    task automatic predict_reading(input logic [7:0] data, input logic kind);
        reading_t     rd;
        if (model_position == 2'd1) begin
            model_low      = data;
            model_crc      = crc8_step(model_crc, data, model_poly);
            model_position = 2'd2;
        end else if (model_position == 2'd2) begin
            rd.raw         = {model_high, model_low};
            rd.crc_ok      = (model_crc == data);
            rd.kind        = kind;
            rd.value       = convert_raw(rd.raw, kind);
            expected_readings.push_back(rd);
            model_position = 2'd0;
            model_crc      = 8'h00;
        end else begin
            model_high     = data;
            model_crc      = crc8_step(8'h00, data, model_poly);
            model_position = 2'd1;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %0s: got %0h, want %0h", what, got, want);
        error_count++;
    endtask

    task automatic push_frame(input logic [15:0] raw, input logic kind, input bit good_crc,
                              input logic [7:0] poly);
        frame_item_t item;
        logic [7:0]  crc;
        crc = crc8_step(crc8_step(8'h00, raw[15:8], poly), raw[7:0], poly);
        if (!good_crc) begin
            crc ^= 8'h01 << $urandom_range(0, 7);
        end
        item.frame_byte = raw[15:8];
        item.measure_kind = 1'($urandom_range(0, 1));
        byte_queue.push_back(item);
        item.frame_byte = raw[7:0];
        item.measure_kind = 1'($urandom_range(0, 1));
        byte_queue.push_back(item);
        item.frame_byte = crc;
        item.measure_kind = kind;
        byte_queue.push_back(item);
    endtask

    task automatic push_random_phase(input logic [7:0] poly);
        frame_item_t item;
        logic [15:0] raw;
        int          pushed;
        int          pick;
        pushed = 0;
        while (pushed < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                item.frame_byte = 8'($urandom_range(0, 255));
                item.measure_kind = 1'($urandom_range(0, 1));
                byte_queue.push_back(item);
                pushed += 1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    raw = 16'($urandom_range(0, 16'h00FF));
                end else if (pick < 20) begin
                    raw = 16'($urandom_range(16'hFF00, 16'hFFFF));
                end else if (pick < 35) begin
                    raw = 16'($urandom_range(16'hD800, 16'hDAFF));
                end else begin
                    raw = 16'($urandom_range(0, 16'hFFFF));
                end
                push_frame(raw, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, poly);
                pushed += 3;
            end
        end
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_poly(input logic [7:0] poly);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= poly;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (cfg_wr_en) begin
            model_poly <= cfg_wr_data;
        end
    end

    always @(posedge aclk) begin
        frame_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reading(s_tdata, s_tuser[0]);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    item = byte_queue.pop_front();
                    s_tdata  <= item.frame_byte;
                    s_tuser  <= item.measure_kind;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    report("unexpected transaction", m_tdata, 32'h0);
                end else begin
                    want = expected_readings.pop_front();
                    if (m_tuser[0] !== want.crc_ok) begin
                        report("crc_ok", 32'(m_tuser[0]), 32'(want.crc_ok));
                    end
                    if (m_tuser[1] !== want.kind) begin
                        report("result_kind", 32'(m_tuser[1]), 32'(want.kind));
                    end
                    if (m_tdata[14:0] !== want.value) begin
                        report("reading_value", 32'(m_tdata[14:0]), 32'(want.value));
                    end
                    if (m_tdata[30:15] !== want.raw) begin
                        report("raw_reading", 32'(m_tdata[30:15]), 32'(want.raw));
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        report("tdata pad", 32'(m_tdata[31]), 32'h0);
                    end
                end
            end
            if (stall_phase == 0) begin
                stall_round++;
                stall_pattern = (stall_round % 4 == 0) ? 16'hFFFF : 16'($urandom());
            end
            m_tready    <= stall_pattern[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [7:0] poly_list[5];
        poly_list = '{8'h00, 8'hFF, 8'h07, 8'h00, 8'h31};
        poly_list[3] = 8'($urandom_range(0, 255));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        write_poly(SCFC_POLY_RESET);
        push_frame(16'h0000, KIND_TEMP, 1'b1, SCFC_POLY_RESET);
        push_frame(16'hFFFF, KIND_TEMP, 1'b1, SCFC_POLY_RESET);
        push_frame(16'hFFFF, KIND_HUMID, 1'b1, SCFC_POLY_RESET);
        push_frame(16'h0000, KIND_HUMID, 1'b0, SCFC_POLY_RESET);
        push_frame(16'h0003, KIND_TEMP, 1'b1, SCFC_POLY_RESET);
        push_frame(16'hD914, KIND_HUMID, 1'b1, SCFC_POLY_RESET);
        push_frame(16'hD918, KIND_HUMID, 1'b0, SCFC_POLY_RESET);
        byte_queue.push_back('{frame_byte: 8'h80, measure_kind: 1'b1});

        foreach (poly_list[i]) begin
            wait_idle();
            write_poly(poly_list[i]);
            push_random_phase(poly_list[i]);
        end
        wait_idle();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/scfc_pkg.sv
hw/rtl/scfc_front.sv
hw/rtl/scfc_queue.sv
hw/rtl/scfc_back.sv
hw/rtl/sensor_frame_crc_convert_core.sv
sim/tb_sensor_frame_crc_convert_core.sv
